[design/wsplit_pkg.sv]
`default_nettype none

package wsplit_pkg;

	localparam int BLANK_SLOTS = 8;
	localparam int SEP_SLOTS   = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CFG_BLANK_LIST   = 3'd0;
	localparam logic [2:0] CFG_SEP_LOW      = 3'd1;
	localparam logic [2:0] CFG_SEP_HIGH     = 3'd2;
	localparam logic [2:0] CFG_STRING_OPEN  = 3'd3;
	localparam logic [2:0] CFG_STRING_CLOSE = 3'd4;

	localparam logic [7:0] QUOTE_RESET = 8'd34;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_STRING = 2'd2,
		MODE_SEP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PLAIN  = 2'd0,
		KIND_STRING = 2'd1,
		KIND_SEP    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		kind_t      kind;
	} entry_t;

	typedef struct packed {
		logic [1:0] cnt;
		entry_t     e0;
		entry_t     e1;
	} push_t;

endpackage

`default_nettype wire

[design/wsplit_front.sv]
`default_nettype none

module wsplit_front import wsplit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        room,
	output push_t       push
);

	logic [63:0]  blank_q;
	logic [63:0]  sep_low_q;
	logic [63:0]  sep_high_q;
	logic [7:0]   open_q;
	logic [7:0]   close_q;
	mode_t        mode_q;
	mode_t        mode_d;
	mode_t        start_mode;
	logic [7:0]   held_q;
	logic         accept;
	logic         c_zero;
	logic         c_blank;
	logic         c_sep_beg;
	logic         pair_hit;
	logic [127:0] sep_all;
	kind_t        cur_kind;

	assign in_ready = room;
	assign accept   = in_valid && room;
	assign c_zero   = (in_char == 8'd0);
	assign sep_all  = {sep_high_q, sep_low_q};

	// set membership: parallel compare against every slot, zero slots skipped
	always_comb begin
		c_blank   = 1'b0;
		c_sep_beg = 1'b0;
		pair_hit  = 1'b0;
		for (int k = 0; k < BLANK_SLOTS; k++) begin
			if (blank_q[8*k +: 8] != 8'd0 && blank_q[8*k +: 8] == in_char)
				c_blank = 1'b1;
		end
		for (int k = 0; k < SEP_SLOTS; k++) begin
			if (sep_all[16*k +: 16] != 16'd0) begin
				if (sep_all[16*k +: 8] == in_char)
					c_sep_beg = 1'b1;
				if (sep_all[16*k +: 16] == {in_char, held_q})
					pair_hit = 1'b1;
			end
		end
	end

	always_comb begin
		if (c_zero || c_blank)
			start_mode = MODE_IDLE;
		else if (in_char == open_q)
			start_mode = MODE_STRING;
		else if (c_sep_beg)
			start_mode = MODE_SEP;
		else
			start_mode = MODE_PLAIN;
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		if (accept) begin
			unique case (mode_q)
				MODE_STRING: begin
					if (c_zero || in_char == close_q)
						mode_d = MODE_IDLE;
					else
						mode_d = MODE_STRING;
				end
				MODE_SEP: begin
					if (c_zero || pair_hit)
						mode_d = MODE_IDLE;
					else
						mode_d = start_mode;
				end
				MODE_PLAIN: begin
					if (c_zero)
						mode_d = MODE_IDLE;
					else if (c_sep_beg || c_blank)
						mode_d = start_mode;
					else
						mode_d = MODE_PLAIN;
				end
				default: mode_d = start_mode;
			endcase
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_STRING: cur_kind = KIND_STRING;
			MODE_SEP:    cur_kind = KIND_SEP;
			default:     cur_kind = KIND_PLAIN;
		endcase
	end

	// outputs: held byte first, then the current byte when it closes a pair
	always_comb begin
		push.cnt     = 2'd0;
		push.e0.ch   = held_q;
		push.e0.last = 1'b1;
		push.e0.kind = cur_kind;
		push.e1.ch   = in_char;
		push.e1.last = 1'b1;
		push.e1.kind = cur_kind;
		if (accept) begin
			unique case (mode_q)
				MODE_STRING: begin
					push.cnt     = 2'd1;
					push.e0.last = c_zero;
					if (!c_zero && in_char == close_q)
						push.cnt = 2'd2;
				end
				MODE_SEP: begin
					push.cnt = 2'd1;
					if (!c_zero && pair_hit) begin
						push.cnt     = 2'd2;
						push.e0.last = 1'b0;
					end
				end
				MODE_PLAIN: begin
					push.cnt     = 2'd1;
					push.e0.last = c_zero || c_sep_beg || c_blank;
				end
				default: push.cnt = 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else begin
			mode_q <= mode_d;
		end
	end

	// held byte only matters while a word is open
	always_ff @(posedge clk) begin
		if (accept)
			held_q <= in_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q    <= '0;
			sep_low_q  <= '0;
			sep_high_q <= '0;
			open_q     <= QUOTE_RESET;
			close_q    <= QUOTE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BLANK_LIST:   blank_q    <= cfg_data;
				CFG_SEP_LOW:      sep_low_q  <= cfg_data;
				CFG_SEP_HIGH:     sep_high_q <= cfg_data;
				CFG_STRING_OPEN:  open_q     <= cfg_data[7:0];
				CFG_STRING_CLOSE: close_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/wsplit_queue.sv]
`default_nettype none

module wsplit_queue import wsplit_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   out_ready,
	output logic   out_valid,
	output entry_t head,
	output logic   room
);

	entry_t               entries_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic [Q_PTR_W-1:0]   wr_ptr_nx;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= Q_CNT_W'(QUEUE_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + Q_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			entries_q[wr_ptr_q] <= push.e0;
		if (push.cnt == 2'd2)
			entries_q[wr_ptr_nx] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			count_q <= count_q + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

[design/word_splitter_top.sv]
// Throughput: one input byte per cycle while the queue has room. A byte that completes two result
//   bytes queues both; the output drains one per cycle while out_ready is high.
// A result is written into the queue registers before it reaches the output;
//   the first byte of a word waits for the next input byte.
// Input stalls only while fewer than two slots of the 4-entry queue are free.
// Reset (arst_n low): queue empty, splitter idle, quotes back to 34, lists cleared.
`default_nettype none

module word_splitter_top import wsplit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        word_end,
	output logic [1:0]  word_kind,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	push_t  push;
	entry_t head;
	logic   room;

	wsplit_front front_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_char),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.room      (room),
		.push      (push)
	);

	wsplit_queue queue_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign out_char  = head.ch;
	assign word_end  = head.last;
	assign word_kind = head.kind;

endmodule

`default_nettype wire

[design/word_splitter_chk.sv]
`default_nettype none

module word_splitter_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_char,
	input logic        word_end,
	input logic [1:0]  word_kind
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
		&& $stable(word_end) && $stable(word_kind))
		else $error("stalled result changed or dropped");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// results only come from accepted requests
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without a request");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind word_splitter_top word_splitter_chk chk_i (.*);

`default_nettype wire
